[rtl/core/lzw_fixed_width_encoder_macros.svh]
// Assertion helpers shared by the encoder files.
`ifndef LZW_FIXED_WIDTH_ENCODER_MACROS_SVH
`define LZW_FIXED_WIDTH_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lzw_fw_pkg.sv]
package lzw_fw_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int MIN_CODE_BITS     = 9;
  // Widest code any build supports; narrower codes are zero-extended.
  localparam int CODE_W            = 16;
  localparam int WIDTH_W           = 5;
  localparam int CFG_W             = 4;
  localparam int CFG_RESET         = 9;
  localparam int FIRST_FREE        = 257;
  localparam int EPOCH_W           = 16;
  localparam int WORD_W            = 64;
  localparam int FILL_W            = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              word_last;
  } out_t;

  // One code handed from the dictionary walker to the bit packer.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
    logic               end_blk;
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_TAIL,
    ST_ENDC
  } state_e;

endpackage

[rtl/core/lzw_fw_ram.sv]
module lzw_fw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lzw_fw_packer.sv]
`include "lzw_fixed_width_encoder_macros.svh"

module lzw_fw_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  lzw_fw_pkg::op_t   op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lzw_fw_pkg::out_t  out_data_o
);

  localparam int WW = lzw_fw_pkg::WORD_W;
  localparam int FW = lzw_fw_pkg::FILL_W;

  logic [WW-1:0]     acc_q, acc_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic              flush_q, flush_d;
  logic              out_valid_q, out_valid_d;
  lzw_fw_pkg::out_t  out_q, out_d;

  logic [2*WW-1:0]   shifted;
  logic [WW-1:0]     acc_new;
  logic [FW:0]       sum;
  logic              can_emit;
  logic              take;

  always_comb begin
    can_emit   = !out_valid_q || out_ready_i;
    op_ready_o = can_emit && !flush_q;
    take       = op_valid_i && op_ready_o;

    // The upper half holds the bits that spill into the next word.
    shifted = {{WW{1'b0}}, WW'(op_i.code)} << fill_q;
    acc_new = acc_q | shifted[WW-1:0];
    sum     = {1'b0, fill_q} + (FW+1)'(op_i.width);

    acc_d       = acc_q;
    fill_d      = fill_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (flush_q) begin
      if (can_emit) begin
        out_valid_d       = 1'b1;
        out_d.packed_word = acc_q;
        out_d.word_last   = 1'b1;
        acc_d             = '0;
        fill_d            = '0;
        flush_d           = 1'b0;
      end
    end else if (take) begin
      if (sum[FW]) begin
        out_valid_d       = 1'b1;
        out_d.packed_word = acc_new;
        out_d.word_last   = op_i.end_blk && (sum[FW-1:0] == '0);
        acc_d             = shifted[2*WW-1:WW];
        fill_d            = sum[FW-1:0];
        if (op_i.end_blk) begin
          if (sum[FW-1:0] == '0) begin
            acc_d = '0;
          end else begin
            flush_d = 1'b1;
          end
        end
      end else if (op_i.end_blk) begin
        out_valid_d       = 1'b1;
        out_d.packed_word = acc_new;
        out_d.word_last   = 1'b1;
        acc_d             = '0;
        fill_d            = '0;
      end else begin
        acc_d  = acc_new;
        fill_d = sum[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LZW_ASSERT_IMP(a_flush_behind_word, clk_i, rst_ni, flush_q, out_valid_q, "flush pending without a held word")
  `LZW_ASSERT_IMP(a_last_empties_acc, clk_i, rst_ni, out_valid_q && out_q.word_last, (fill_q == '0) && !flush_q, "bits left after final word")
  `LZW_ASSERT_NXT(a_end_emits, clk_i, rst_ni, take && op_i.end_blk, out_valid_q, "end code produced no word")

endmodule

[rtl/core/lzw_fixed_width_encoder.sv]
// LZW encoder with fixed-width codes, packed LSB first into 64-bit words.
// Input channel (in_valid_i/in_ready_o, in_data_i): one byte per transfer,
// block_end set on the final byte of a block. Output channel
// (out_valid_o/out_ready_i, out_data_o): packed words, word_last set on the
// flushed final word of each block. cfg_we_i loads the code width at once.
// A byte's transfer is followed by a LOOKUP state before the next byte is taken,
// set by the dependent dictionary read (the next byte's table address needs the
// node found for this one). The final byte of a block also passes TAIL and ENDC.
// Codes wait in the one-code stage until the packer takes them with any word they complete.
// Reset: the dictionary memory is swept for 2^(MAX_CODE_BITS+8) cycles
// while in_ready_o is low. Each block bumps a 16-bit epoch tag instead of
// clearing the table; once every 65535 blocks the same sweep runs again.
// A stalled receiver fills the output register and the one-code stage in
// front of the packer; after that in_ready_o drops until words drain.
`include "lzw_fixed_width_encoder_macros.svh"

module lzw_fixed_width_encoder #(
  parameter int MAX_CODE_BITS = lzw_fw_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lzw_fw_pkg::in_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lzw_fw_pkg::out_t             out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lzw_fw_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int NODE_W  = MAX_CODE_BITS;
  localparam int ADDR_W  = NODE_W + 8;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int WID_W   = $clog2(MAX_CODE_BITS + 1);
  localparam int EP_W    = lzw_fw_pkg::EPOCH_W;
  localparam int ENTRY_W = EP_W + NODE_W;

  typedef struct packed {
    logic [EP_W-1:0]   tag;
    logic [NODE_W-1:0] child;
  } entry_t;

  lzw_fw_pkg::state_e           state_q, state_d;
  logic [NODE_W-1:0]            cur_node_q, cur_node_d;
  logic [NODE_W:0]              free_q, free_d;
  logic [EP_W-1:0]              epoch_q, epoch_d;
  logic [ADDR_W-1:0]            slot_q, slot_d;
  logic                         last_q, last_d;
  logic [ADDR_W-1:0]            sweep_q, sweep_d;
  logic [lzw_fw_pkg::CFG_W-1:0] code_bits_q;
  logic                         op_valid_q, op_valid_d;
  lzw_fw_pkg::op_t              op_q, op_d;
  logic                         op_ready;

  logic [WID_W-1:0]             w_eff;
  logic [NODE_W:0]              limit;
  logic [NODE_W-1:0]            code_mask;
  logic                         room;
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  entry_t                       ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  entry_t                       ram_rdata;
  logic [NODE_W-1:0]            byte_node;
  logic                         hit;
  logic                         push;
  logic                         in_accept;
  logic                         slot_free;

  // Width below the minimum acts as the minimum, above the build maximum as the maximum.
  always_comb begin
    if (32'(code_bits_q) < lzw_fw_pkg::MIN_CODE_BITS) begin
      w_eff = WID_W'(lzw_fw_pkg::MIN_CODE_BITS);
    end else if (32'(code_bits_q) > MAX_CODE_BITS) begin
      w_eff = WID_W'(MAX_CODE_BITS);
    end else begin
      w_eff = WID_W'(code_bits_q);
    end
    limit     = (NODE_W+1)'(1) << w_eff;
    // At full width the low bits of the limit are zero, so this wraps to all ones.
    code_mask = limit[NODE_W-1:0] - NODE_W'(1);
    room      = free_q < limit;
  end

  assign slot_free = !op_valid_q || op_ready;
  assign in_accept = in_valid_i && in_ready_o;
  assign ram_raddr = {cur_node_q, in_data_i.data_byte};
  assign byte_node = NODE_W'(slot_q[7:0]) + NODE_W'(1);
  // Root children are fixed; other entries count only when written in this block.
  assign hit = (cur_node_q == '0) || (ram_rdata.tag == epoch_q);

  always_comb begin
    state_d    = state_q;
    cur_node_d = cur_node_q;
    free_d     = free_q;
    epoch_d    = epoch_q;
    slot_d     = slot_q;
    last_d     = last_q;
    sweep_d    = sweep_q;
    op_d       = op_q;
    push       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = slot_q;
    ram_wdata  = '0;
    in_ready_o = 1'b0;

    case (state_q)
      lzw_fw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        sweep_d   = sweep_q + ADDR_W'(1);
        if (sweep_q == '1) begin
          state_d = lzw_fw_pkg::ST_IDLE;
        end
      end
      lzw_fw_pkg::ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          slot_d  = ram_raddr;
          last_d  = in_data_i.block_end;
          state_d = lzw_fw_pkg::ST_LOOKUP;
        end
      end
      lzw_fw_pkg::ST_LOOKUP: begin
        if (hit) begin
          cur_node_d = (cur_node_q == '0) ? byte_node : ram_rdata.child;
        end else begin
          push         = 1'b1;
          op_d.code    = lzw_fw_pkg::CODE_W'((cur_node_q - NODE_W'(1)) & code_mask);
          op_d.width   = lzw_fw_pkg::WIDTH_W'(w_eff);
          op_d.end_blk = 1'b0;
          if (room) begin
            ram_we          = 1'b1;
            ram_wdata.tag   = epoch_q;
            ram_wdata.child = free_q[NODE_W-1:0];
            free_d          = free_q + (NODE_W+1)'(1);
          end
          cur_node_d = byte_node;
        end
        state_d = last_q ? lzw_fw_pkg::ST_TAIL : lzw_fw_pkg::ST_IDLE;
      end
      lzw_fw_pkg::ST_TAIL: begin
        if (slot_free) begin
          push         = 1'b1;
          op_d.code    = lzw_fw_pkg::CODE_W'((cur_node_q - NODE_W'(1)) & code_mask);
          op_d.width   = lzw_fw_pkg::WIDTH_W'(w_eff);
          op_d.end_blk = 1'b0;
          state_d      = lzw_fw_pkg::ST_ENDC;
        end
      end
      lzw_fw_pkg::ST_ENDC: begin
        if (slot_free) begin
          push         = 1'b1;
          op_d.code    = lzw_fw_pkg::CODE_W'(code_mask);
          op_d.width   = lzw_fw_pkg::WIDTH_W'(w_eff);
          op_d.end_blk = 1'b1;
          cur_node_d   = '0;
          free_d       = (NODE_W+1)'(lzw_fw_pkg::FIRST_FREE);
          if (epoch_q == '1) begin
            // Old tags would alias the restarted epoch, so wipe the table.
            epoch_d = EP_W'(1);
            sweep_d = '0;
            state_d = lzw_fw_pkg::ST_CLEAR;
          end else begin
            epoch_d = epoch_q + EP_W'(1);
            state_d = lzw_fw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lzw_fw_pkg::ST_IDLE;
      end
    endcase

    op_valid_d = push || (op_valid_q && !op_ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzw_fw_pkg::ST_CLEAR;
      cur_node_q  <= '0;
      free_q      <= (NODE_W+1)'(lzw_fw_pkg::FIRST_FREE);
      epoch_q     <= EP_W'(1);
      sweep_q     <= '0;
      code_bits_q <= lzw_fw_pkg::CFG_W'(lzw_fw_pkg::CFG_RESET);
      op_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_node_q <= cur_node_d;
      free_q     <= free_d;
      epoch_q    <= epoch_d;
      sweep_q    <= sweep_d;
      op_valid_q <= op_valid_d;
      if (cfg_we_i) begin
        code_bits_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    last_q <= last_d;
    op_q   <= op_d;
  end

  lzw_fw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lzw_fw_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid_q),
    .op_ready_o  (op_ready),
    .op_i        (op_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `LZW_ASSERT_NXT(a_accept_lookup, clk_i, rst_ni, in_accept,
                  state_q == lzw_fw_pkg::ST_LOOKUP, "transfer not followed by lookup")
  `LZW_ASSERT_IMP(a_push_has_slot, clk_i, rst_ni, push, slot_free,
                  "code pushed into an occupied stage")
  `LZW_ASSERT_IMP(a_node_allocated, clk_i, rst_ni, 1'b1, cur_node_q < free_q,
                  "current node beyond allocated nodes")
  `LZW_ASSERT_IMP(a_hit_child_valid, clk_i, rst_ni,
                  (state_q == lzw_fw_pkg::ST_LOOKUP) && (cur_node_q != '0) &&
                  (ram_rdata.tag == epoch_q),
                  (ram_rdata.child >= NODE_W'(lzw_fw_pkg::FIRST_FREE)) &&
                  (ram_rdata.child < free_q),
                  "tagged entry holds an unallocated child")
  `LZW_ASSERT_IMP(a_epoch_nonzero, clk_i, rst_ni, 1'b1, epoch_q != '0,
                  "epoch matches swept entries")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD = 10;
  localparam int MAX_W = lzw_fw_pkg::MAX_CODE_BITS_DEF;
  localparam int WORD_BITS = lzw_fw_pkg::WORD_W;
  // The dictionary sweep after reset covers all 2^(MAX_W+8) entries with in_ready_o low.
  localparam longint SWEEP_CYCLES = 64'd1 << (MAX_W + 8);
  localparam longint TIMEOUT_NS = 64'd3 * (SWEEP_CYCLES + 64'd150000) * CLK_PERIOD;
  localparam int TARGET_BYTES = 1025;
  // A byte that emits nothing may still be inside the pipeline; the final byte
  // also passes TAIL and ENDC before its closing codes reach the packer.
  localparam int SETTLE_CYCLES = 12;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
  typedef enum {PAT_RANDOM, PAT_ALPHABET, PAT_RUN} byte_pattern_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lzw_fw_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lzw_fw_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [lzw_fw_pkg::CFG_W-1:0] cfg_data = '0;

  // Encoder image kept by the testbench.
  bit [3:0] width_reg = 4'(lzw_fw_pkg::CFG_RESET);
  bit [11:0] cur_node = '0;
  bit [12:0] free_node = 13'(lzw_fw_pkg::FIRST_FREE);
  bit [63:0] acc_bits = '0;
  int unsigned acc_fill = 0;
  bit [11:0] child_of [int unsigned];
  lzw_fw_pkg::out_t pending_words[$];

  int error_count = 0;
  int bytes_sent = 0;
  int blocks_sent = 0;
  int words_checked = 0;
  int width_changes_in_block = 0;
  bit [15:0] widths_written = '0;
  int burst_left = 0;
  lzw_fw_pkg::out_t word_want;
  rx_mode_e rx_mode = RX_OPEN;
  int rx_left = 0;

  lzw_fixed_width_encoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned code_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < lzw_fw_pkg::MIN_CODE_BITS) w = lzw_fw_pkg::MIN_CODE_BITS;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic void pack_code(input int unsigned code, input int unsigned w,
                                    ref lzw_fw_pkg::out_t words[$]);
    bit [63:0] c;
    c = 64'(code & ((32'd1 << w) - 1));
    acc_bits |= c << acc_fill;
    if (acc_fill + w >= WORD_BITS) begin
      words.push_back('{packed_word: acc_bits, word_last: 1'b0});
      acc_bits = (acc_fill == 0) ? 64'd0 : (c >> (WORD_BITS - acc_fill));
      acc_fill = acc_fill + w - WORD_BITS;
    end else begin
      acc_fill += w;
    end
  endfunction

  function automatic void encode_byte(input lzw_fw_pkg::in_t item);
    int unsigned w;
    int unsigned limit;
    int unsigned slot;
    int unsigned child;
    lzw_fw_pkg::out_t words[$];
    w = code_width();
    limit = 32'd1 << w;
    slot = cur_node * 256 + item.data_byte;
    // The root always has a child for every byte: node byte+1.
    if (cur_node == 0) child = item.data_byte + 1;
    else if (child_of.exists(slot)) child = child_of[slot];
    else child = 0;
    if (child == 0) begin
      if (free_node < limit) begin
        child_of[slot] = free_node[11:0];
        free_node++;
      end
      pack_code(cur_node - 1, w, words);
      cur_node = 12'(item.data_byte + 1);
    end else begin
      cur_node = child[11:0];
    end
    if (item.block_end) begin
      pack_code(cur_node - 1, w, words);
      pack_code(limit - 1, w, words);
      if (acc_fill != 0) words.push_back('{packed_word: acc_bits, word_last: 1'b0});
      words[words.size() - 1].word_last = 1'b1;
      child_of.delete();
      cur_node = '0;
      free_node = 13'(lzw_fw_pkg::FIRST_FREE);
      acc_bits = '0;
      acc_fill = 0;
    end
    foreach (words[i]) pending_words.push_back(words[i]);
  endfunction

  // One byte transfer; the sender runs in bursts with random gaps between them.
  task automatic send_byte(input logic [7:0] value, input logic is_end);
    lzw_fw_pkg::in_t item;
    int gap;
    item.data_byte = value;
    item.block_end = is_end;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    encode_byte(item);
    bytes_sent++;
    if (is_end) blocks_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_bits(input logic [lzw_fw_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg = value;
    widths_written[value] = 1'b1;
  endtask

  task automatic test_one_byte_blocks();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
  endtask

  // Fifteen distinct rising bytes at 12 bits give sixteen codes: three full
  // words, so the last one carries word_last and nothing is flushed.
  task automatic test_exact_full_word();
    drain();
    write_code_bits(4'd12);
    for (int b = 1; b <= 15; b++) send_byte(8'(b), b == 15);
  endtask

  task automatic test_width_change_in_block();
    drain();
    write_code_bits(4'd0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    drain();
    write_code_bits(4'd15);
    width_changes_in_block++;
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b1);
  endtask

  task automatic test_random_blocks();
    int len;
    int split;
    int alpha;
    bit long_blk;
    byte_pattern_e pattern;
    logic [7:0] base;
    logic [7:0] value;
    while (bytes_sent < TARGET_BYTES) begin
      drain();
      // Long blocks run at narrow widths so that the dictionary fills up.
      long_blk = ($urandom_range(0, 7) == 0);
      write_code_bits(long_blk ? 4'($urandom_range(0, 10)) : 4'($urandom_range(0, 15)));
      len = long_blk ? $urandom_range(260, 420) : $urandom_range(1, 40);
      split = (len > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, len - 1) : 0;
      pattern = byte_pattern_e'($urandom_range(0, 2));
      base = 8'($urandom);
      alpha = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        if (split != 0 && i == split) begin
          drain();
          write_code_bits(4'($urandom_range(0, 15)));
          width_changes_in_block++;
        end
        case (pattern)
          PAT_ALPHABET: value = base + 8'($urandom_range(0, alpha - 1));
          PAT_RUN:      value = ($urandom_range(0, 7) == 0) ? 8'($urandom) : base;
          default:      value = 8'($urandom);
        endcase
        send_byte(value, i == len - 1);
      end
    end
  endtask

  // Receiver stalls follow one of four random modes; a new mode is drawn when rx_left runs out.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= ((rx_left % 16) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected packed word %h (word_last %0b)", out_data.packed_word,
               out_data.word_last);
        error_count++;
      end else begin
        word_want = pending_words.pop_front();
        if (out_data.packed_word !== word_want.packed_word) begin
          $error("packed_word: expected %h, actual %h", word_want.packed_word,
                 out_data.packed_word);
          error_count++;
        end
        if (out_data.word_last !== word_want.word_last) begin
          $error("word_last: expected %0b, actual %0b", word_want.word_last,
                 out_data.word_last);
          error_count++;
        end
        words_checked++;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_one_byte_blocks();
    test_exact_full_word();
    test_width_change_in_block();
    test_random_blocks();
    drain();
    $display("Encoded %0d bytes in %0d blocks; %0d packed words checked.",
             bytes_sent, blocks_sent, words_checked);
    $display("Width values written (bit n for value n): %b; %0d changes inside a block.",
             widths_written, width_changes_in_block);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d words still expected.", pending_words.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
